// ===== src/call_stack_profiler_defines.svh =====
// Assertion macros for the call stack profiler.
// Used by the top level; no other dependencies.
`ifndef CALL_STACK_PROFILER_DEFINES_SVH
`define CALL_STACK_PROFILER_DEFINES_SVH
`ifndef SYNTHESIS
`define CSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/csp_pkg.sv =====
// Shared constants, types and helpers for the call stack profiler.
// No dependencies.
package csp_pkg;
  localparam int FUNC_ENTRIES = 1024;
  localparam int STACK_FRAMES = 4096;
  localparam int FID_W = 10;
  localparam int TIME_W = 63;
  localparam int CNT_W = 32;
  localparam int DEPTH_W = $clog2(STACK_FRAMES) + 1;
  localparam int SP_W = $clog2(STACK_FRAMES);
  localparam int USED_W = $clog2(FUNC_ENTRIES) + 1;
  localparam int EIDX_W = $clog2(FUNC_ENTRIES);
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] TPS_RESET = 63'd10000000;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_ENTER = 2'd1;
  localparam logic [1:0] OP_EXIT  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TABLE    = 3'd4;

  typedef struct packed {
    logic start;
    logic [TIME_W-1:0] ticks;
  } conv_req_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction
endpackage

// ===== src/call_stack_profiler.sv =====
// call_stack_profiler: one item at a time; a new item is taken only in the idle
// state. csp_conv runs one conversion per enter with a caller and two per
// exit, and ends a conversion early when it saturates. A result waits in the
// output register while the next item is taken. Reset (rst_n low, synchronous)
// clears stack depth, entry count and sequencer; frequency returns to 10000000.
`include "call_stack_profiler_defines.svh"
module call_stack_profiler
  import csp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [62:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // op[1:0], func_id[11:2], now[74:12]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [183:0] out_tdata   // status, entry_id, call_count, total_us,
                                   // self_us, depth
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_RDW = 4'd2, S_C1 = 4'd3,
    S_C1W = 4'd4, S_C2 = 4'd5, S_C2W = 4'd6, S_ERD = 4'd7, S_EUPD = 4'd8,
    S_CRD = 4'd9, S_CUPD = 4'd10, S_ORD = 4'd11, S_OUT = 4'd12;

  logic [3:0] st_r, st_nxt;
  logic [TIME_W-1:0] tps_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [1:0] op_r, op_nxt;
  logic [FID_W-1:0] fid_r, fid_nxt, eid_r, eid_nxt, cf_r, cf_nxt;
  logic [TIME_W-1:0] now_r, now_nxt, gs_r, gs_nxt, ls_r, ls_nxt;
  logic [TIME_W-1:0] d1_r, d1_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic ovalid_r, ovalid_nxt;
  logic [183:0] odata_r, odata_nxt;

  logic [SP_W-1:0] sp_raddr, sp_waddr;
  logic f_we, l_we, g_we;
  logic [FID_W-1:0] f_wd, f_rd;
  logic [TIME_W-1:0] l_wd, l_rd, g_rd;
  logic [EIDX_W-1:0] e_raddr, e_waddr;
  logic e_we;
  logic [CNT_W-1:0] c_wd, c_rd;
  logic [TIME_W-1:0] t_wd, t_rd, s_wd, s_rd;
  conv_req_t creq;
  logic cdone;
  logic [TIME_W-1:0] cus;

  assign cfg_ready = (st_r == S_IDLE);
  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  csp_ram #(.WIDTH(FID_W), .DEPTH(STACK_FRAMES)) u_ff (.clk(clk), .we(f_we),
    .waddr(sp_waddr), .wdata(f_wd), .raddr(sp_raddr), .rdata(f_rd));
  csp_ram #(.WIDTH(TIME_W), .DEPTH(STACK_FRAMES)) u_fg (.clk(clk), .we(g_we),
    .waddr(sp_waddr), .wdata(now_r), .raddr(sp_raddr), .rdata(g_rd));
  csp_ram #(.WIDTH(TIME_W), .DEPTH(STACK_FRAMES)) u_fl (.clk(clk), .we(l_we),
    .waddr(sp_waddr), .wdata(l_wd), .raddr(sp_raddr), .rdata(l_rd));
  csp_ram #(.WIDTH(CNT_W), .DEPTH(FUNC_ENTRIES)) u_ec (.clk(clk), .we(e_we),
    .waddr(e_waddr), .wdata(c_wd), .raddr(e_raddr), .rdata(c_rd));
  csp_ram #(.WIDTH(TIME_W), .DEPTH(FUNC_ENTRIES)) u_et (.clk(clk), .we(e_we),
    .waddr(e_waddr), .wdata(t_wd), .raddr(e_raddr), .rdata(t_rd));
  csp_ram #(.WIDTH(TIME_W), .DEPTH(FUNC_ENTRIES)) u_es (.clk(clk), .we(e_we),
    .waddr(e_waddr), .wdata(s_wd), .raddr(e_raddr), .rdata(s_rd));

  csp_conv u_conv (.clk(clk), .rst_n(rst_n), .req(creq), .freq(tps_r),
    .done(cdone), .us(cus));

  // top frame index before a pop, or caller frame after it
  logic [DEPTH_W-1:0] dm1;
  assign dm1 = depth_r - DEPTH_W'(1);

  always_comb begin
    st_nxt = st_r; depth_nxt = depth_r; used_nxt = used_r; op_nxt = op_r;
    fid_nxt = fid_r; eid_nxt = eid_r; cf_nxt = cf_r; now_nxt = now_r;
    gs_nxt = gs_r; ls_nxt = ls_r; d1_nxt = d1_r; stat_nxt = stat_r;
    ovalid_nxt = ovalid_r; odata_nxt = odata_r;
    sp_raddr = dm1[SP_W-1:0]; sp_waddr = depth_r[SP_W-1:0];
    f_we = 1'b0; g_we = 1'b0; l_we = 1'b0; f_wd = fid_r; l_wd = now_r;
    e_raddr = eid_r; e_waddr = eid_r; e_we = 1'b0;
    c_wd = c_rd; t_wd = t_rd; s_wd = s_rd;
    creq.start = 1'b0; creq.ticks = now_r - ls_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        op_nxt = in_tdata[1:0]; fid_nxt = in_tdata[11:2]; eid_nxt = in_tdata[11:2];
        now_nxt = in_tdata[74:12]; stat_nxt = ST_OK; st_nxt = S_DISP;
      end
      S_DISP: begin
        // frame read of the top entry is issued here
        st_nxt = S_ORD;
        case (op_r)
          OP_ALLOC: if (used_r >= USED_W'(FUNC_ENTRIES)) stat_nxt = ST_TABLE;
            else begin
              eid_nxt = used_r[EIDX_W-1:0]; used_nxt = used_r + USED_W'(1);
              e_waddr = used_r[EIDX_W-1:0]; e_we = 1'b1;
              c_wd = '0; t_wd = '0; s_wd = '0;
            end
          OP_ENTER: if (depth_r >= DEPTH_W'(STACK_FRAMES)) stat_nxt = ST_FULL;
            else if (depth_r != '0) st_nxt = S_RDW;
            else st_nxt = S_CRD;
          OP_EXIT: if (depth_r == '0) stat_nxt = ST_EMPTY;
            else begin
              depth_nxt = dm1; st_nxt = S_RDW;
            end
          OP_READ: ;
          default: ;
        endcase
      end
      S_RDW: begin
        cf_nxt = f_rd; gs_nxt = g_rd; ls_nxt = l_rd;
        if (op_r == OP_EXIT) begin
          if (f_rd != fid_r) stat_nxt = ST_MISMATCH;
          cf_nxt = fid_r;
        end
        st_nxt = S_C1;
      end
      S_C1: begin
        creq.start = 1'b1; creq.ticks = now_r - ls_r; st_nxt = S_C1W;
      end
      S_C1W: if (cdone) begin
        d1_nxt = cus;
        st_nxt = (op_r == OP_EXIT) ? S_C2 : S_ERD;
      end
      S_C2: begin
        creq.start = 1'b1; creq.ticks = now_r - gs_r; st_nxt = S_C2W;
      end
      S_C2W: if (cdone) begin
        // gs_r now holds the inclusive time; restart the caller's local clock
        gs_nxt = cus; st_nxt = S_ERD;
        if (depth_r != '0) begin
          sp_waddr = dm1[SP_W-1:0]; l_we = 1'b1;
        end
      end
      S_ERD: begin
        e_raddr = cf_r; st_nxt = S_EUPD;
      end
      S_EUPD: begin
        e_raddr = cf_r; e_waddr = cf_r; e_we = 1'b1;
        s_wd = sat_add(s_rd, d1_r);
        if (op_r == OP_EXIT) t_wd = sat_add(t_rd, gs_r);
        st_nxt = (op_r == OP_ENTER) ? S_CRD : S_ORD;
      end
      S_CRD: begin
        e_raddr = fid_r; st_nxt = S_CUPD;
      end
      S_CUPD: begin
        // count the call and push the frame
        e_raddr = fid_r; e_waddr = fid_r; e_we = 1'b1;
        c_wd = (c_rd == '1) ? c_rd : c_rd + CNT_W'(1);
        f_we = 1'b1; g_we = 1'b1; l_we = 1'b1;
        depth_nxt = depth_r + DEPTH_W'(1); st_nxt = S_ORD;
      end
      S_ORD: st_nxt = S_OUT; // entry read of eid_r in flight
      S_OUT: if (!ovalid_r || out_tready) begin
        ovalid_nxt = 1'b1;
        odata_nxt = {depth_r, s_rd, t_rd, c_rd, eid_r, stat_r};
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; depth_r <= '0; used_r <= '0; ovalid_r <= 1'b0;
      tps_r <= TPS_RESET;
    end else begin
      st_r <= st_nxt; depth_r <= depth_nxt; used_r <= used_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) tps_r <= cfg_data;
    end
    op_r <= op_nxt; fid_r <= fid_nxt; eid_r <= eid_nxt; cf_r <= cf_nxt;
    now_r <= now_nxt; gs_r <= gs_nxt; ls_r <= ls_nxt; d1_r <= d1_nxt;
    stat_r <= stat_nxt; odata_r <= odata_nxt;
  end

  `CSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `CSP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `CSP_ASSERT_IMPL(a_depth_max, clk, rst_n, 1'b1, depth_r <= DEPTH_W'(STACK_FRAMES))
  `CSP_ASSERT_IMPL(a_used_max, clk, rst_n, 1'b1, used_r <= USED_W'(FUNC_ENTRIES))
endmodule

// ===== src/csp_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module csp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/csp_conv.sv =====
// Tick to microsecond converter: multiply by 1e6 in two halves, check for
// saturation, then a restoring divider one quotient bit a cycle. Uses csp_pkg.
module csp_conv
  import csp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  conv_req_t         req,
  input  logic [TIME_W-1:0] freq,
  output logic              done,
  output logic [TIME_W-1:0] us
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MLO = 3'd1, S_MHI = 3'd2, S_CHK = 3'd3,
                         S_DIV = 3'd4;
  logic [2:0] st_r, st_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [82:0] prod_r, prod_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [TIME_W-1:0] ticks_r, ticks_nxt;
  logic [TIME_W-1:0] fq;
  logic [64:0] sh;
  logic done_r, done_nxt;
  logic [TIME_W-1:0] us_r, us_nxt;

  assign fq = (freq == '0) ? {{(TIME_W-1){1'b0}}, 1'b1} : freq;
  // low product bits enter MSB first
  assign sh = {rem_r, prod_r[~cnt_r[5:0]]};
  assign done = done_r;
  assign us = us_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; prod_nxt = prod_r; rem_nxt = rem_r;
    q_nxt = q_r; ticks_nxt = ticks_r; done_nxt = 1'b0; us_nxt = us_r;
    case (st_r)
      S_IDLE: if (req.start) begin
        ticks_nxt = req.ticks; st_nxt = S_MLO;
      end
      S_MLO: begin
        prod_nxt = {51'd0, ticks_r[31:0]} * {63'd0, US_PER_S};
        st_nxt = S_MHI;
      end
      S_MHI: begin
        prod_nxt = prod_r + ({52'd0, ticks_r[62:32]} * {63'd0, US_PER_S} << 32);
        st_nxt = S_CHK;
      end
      S_CHK: begin
        rem_nxt = {45'd0, prod_r[82:64]}; q_nxt = '0; cnt_nxt = '0;
        if (prod_r[82:64] >= fq) begin
          us_nxt = TIME_MAX; done_nxt = 1'b1; st_nxt = S_IDLE;
        end else st_nxt = S_DIV;
      end
      S_DIV: begin
        if (sh >= {2'b0, fq}) begin
          rem_nxt = 64'(sh - {2'b0, fq}); q_nxt = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = sh[63:0]; q_nxt = {q_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          us_nxt = q_nxt[63] ? TIME_MAX : q_nxt[TIME_W-1:0];
          done_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt; prod_r <= prod_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    ticks_r <= ticks_nxt; us_r <= us_nxt;
  end
endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for call_stack_profiler: a directed table, then random
// allocate/enter/exit/read traffic predicted in the bench, with checks per item.
// Depends on csp_pkg and the call_stack_profiler RTL.
`timescale 1ns / 1ps
module tb_top
  import csp_pkg::*;
();

  localparam logic [62:0] MASK63 = {63{1'b1}};
  localparam int CYCLE_LIMIT = 4000000;

  // status sits in the low bits of out_tdata
  typedef struct packed {
    logic [12:0] depth;
    logic [62:0] self_us;
    logic [62:0] total_us;
    logic [31:0] calls;
    logic [9:0]  entry_id;
    logic [2:0]  status;
  } profile_res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  fid;
    logic [62:0] now;
    bit          fixed;
    logic [2:0]  st;
    logic [12:0] dep;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [62:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;    // op, func_id, now, zero pad
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [183:0] out_tdata;       // status, entry_id, call_count, total_us, self_us, depth

  call_stack_profiler uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // bench copy of the profiler state
  logic [62:0] tick_rate;
  logic [31:0] calls_tbl[FUNC_ENTRIES];
  logic [62:0] total_tbl[FUNC_ENTRIES];
  logic [62:0] self_tbl[FUNC_ENTRIES];
  logic [9:0]  fr_func[STACK_FRAMES];
  logic [62:0] fr_gstart[STACK_FRAMES];
  logic [62:0] fr_lstart[STACK_FRAMES];
  int          stack_lvl;
  int          used_cnt;

  profile_res_t expected_q[$];
  int  errors = 0;
  int  checked = 0;
  int  cycles = 0;
  bit  quiet = 0;
  logic [62:0] clock_now = '0;

  function automatic logic [62:0] ticks_to_us(logic [62:0] ticks, logic [62:0] rate);
    logic [127:0] prod;
    logic [127:0] q;
    logic [62:0]  f;
    f = (rate == 0) ? 63'd1 : rate;
    prod = 128'(ticks) * 128'd1000000;
    q = prod / 128'(f);
    return (q > 128'(MASK63)) ? MASK63 : q[62:0];
  endfunction

  function automatic logic [62:0] add_sat(logic [62:0] a, logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? MASK63 : s[62:0];
  endfunction

  task automatic predict_event(input logic [1:0] op, input logic [9:0] fid,
                               input logic [62:0] now, output profile_res_t r);
    int t;
    r = '0;
    r.status = ST_OK;
    r.entry_id = fid;
    case (op)
      OP_ALLOC: begin
        if (used_cnt >= FUNC_ENTRIES) r.status = ST_TABLE;
        else begin
          r.entry_id = used_cnt[9:0];
          calls_tbl[used_cnt] = '0;
          total_tbl[used_cnt] = '0;
          self_tbl[used_cnt] = '0;
          used_cnt++;
        end
      end
      OP_ENTER: begin
        if (stack_lvl >= STACK_FRAMES) r.status = ST_FULL;
        else begin
          if (stack_lvl > 0) begin
            t = stack_lvl - 1;
            self_tbl[fr_func[t]] = add_sat(self_tbl[fr_func[t]],
                                           ticks_to_us(now - fr_lstart[t], tick_rate));
          end
          if (calls_tbl[fid] != 32'hFFFF_FFFF) calls_tbl[fid]++;
          fr_func[stack_lvl] = fid;
          fr_gstart[stack_lvl] = now;
          fr_lstart[stack_lvl] = now;
          stack_lvl++;
        end
      end
      OP_EXIT: begin
        if (stack_lvl == 0) r.status = ST_EMPTY;
        else begin
          stack_lvl--;
          t = stack_lvl;
          if (fr_func[t] != fid) r.status = ST_MISMATCH;
          total_tbl[fid] = add_sat(total_tbl[fid], ticks_to_us(now - fr_gstart[t], tick_rate));
          self_tbl[fid] = add_sat(self_tbl[fid], ticks_to_us(now - fr_lstart[t], tick_rate));
          if (stack_lvl > 0) fr_lstart[stack_lvl - 1] = now;
        end
      end
      default: ;
    endcase
    r.calls = calls_tbl[r.entry_id];
    r.total_us = total_tbl[r.entry_id];
    r.self_us = self_tbl[r.entry_id];
    r.depth = stack_lvl[12:0];
  endtask

  // one item; sometimes idles afterwards for a random stretch unless quiet
  task automatic send_event(input logic [1:0] op, input logic [9:0] fid,
                            input logic [62:0] now, input bit fixed = 0,
                            input logic [2:0] st = '0, input logic [12:0] dep = '0);
    profile_res_t r;
    in_tdata <= {5'b0, now, fid, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    predict_event(op, fid, now, r);
    if (fixed) begin
      r.status = st;
      r.depth = dep;
    end
    expected_q.push_back(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic set_rate(input logic [62:0] value);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    tick_rate = value;
  endtask

  task automatic random_event();
    int sel;
    logic [9:0] fid;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_now = 63'({$urandom, $urandom});
    else if ($urandom_range(0, 9) == 0) clock_now += 63'({$urandom_range(0, 65535), $urandom});
    else clock_now += 63'($urandom_range(0, 200000));
    fid = 10'($urandom_range(0, used_cnt - 1));
    if (sel < 5) send_event(OP_ALLOC, 10'($urandom), clock_now);
    else if (sel < 12) send_event(OP_READ, fid, clock_now);
    else if (sel < 55 - (stack_lvl > 12 ? 20 : 0)) send_event(OP_ENTER, fid, clock_now);
    else begin
      // mostly a well-formed return, sometimes a wrong id
      if (stack_lvl > 0 && $urandom_range(0, 9) != 0) fid = fr_func[stack_lvl - 1];
      send_event(OP_EXIT, fid, clock_now);
    end
  endtask

  // result side stalls
  initial begin
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    profile_res_t got;
    profile_res_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: %h", out_tdata);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        checked <= checked + 1;
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got.status);
          errors++;
        end
        if (got.entry_id !== exp_r.entry_id) begin
          $error("entry_id: expected %0d, got %0d", exp_r.entry_id, got.entry_id);
          errors++;
        end
        if (got.calls !== exp_r.calls) begin
          $error("call_count: expected %0d, got %0d", exp_r.calls, got.calls);
          errors++;
        end
        if (got.total_us !== exp_r.total_us) begin
          $error("total_us: expected %0d, got %0d", exp_r.total_us, got.total_us);
          errors++;
        end
        if (got.self_us !== exp_r.self_us) begin
          $error("self_us: expected %0d, got %0d", exp_r.self_us, got.self_us);
          errors++;
        end
        if (got.depth !== exp_r.depth) begin
          $error("depth: expected %0d, got %0d", exp_r.depth, got.depth);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  stim_row_t dir_rows[14] = '{
    '{OP_ALLOC, 10'd9,    63'd0,        1'b1, ST_OK,       13'd0},
    '{OP_ALLOC, 10'd0,    63'd0,        1'b1, ST_OK,       13'd0},
    '{OP_EXIT,  10'd0,    63'd0,        1'b1, ST_EMPTY,    13'd0},
    '{OP_READ,  10'd0,    63'd0,        1'b1, ST_OK,       13'd0},
    '{OP_ENTER, 10'd0,    63'd0,        1'b1, ST_OK,       13'd1},
    '{OP_ENTER, 10'd1,    63'd1000,     1'b1, ST_OK,       13'd2},
    '{OP_EXIT,  10'd1,    63'd3000,     1'b1, ST_OK,       13'd1},
    '{OP_EXIT,  10'd0,    63'd10000000, 1'b1, ST_OK,       13'd0},
    '{OP_ENTER, 10'd0,    MASK63,       1'b1, ST_OK,       13'd1},
    '{OP_EXIT,  10'd0,    63'd5,        1'b0, ST_OK,       13'd0},  // counter wrap
    '{OP_ENTER, 10'd1,    63'd100,      1'b1, ST_OK,       13'd1},
    '{OP_EXIT,  10'd0,    63'd200,      1'b1, ST_MISMATCH, 13'd0},
    '{OP_READ,  10'd1,    MASK63,       1'b0, ST_OK,       13'd0},
    '{OP_ALLOC, 10'h3FF,  MASK63,       1'b1, ST_OK,       13'd0}
  };

  initial begin
    logic [62:0] rates[6];
    tick_rate = 63'd10000000;
    stack_lvl = 0;
    used_cnt = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_event(dir_rows[i].op, dir_rows[i].fid, dir_rows[i].now,
                 dir_rows[i].fixed, dir_rows[i].st, dir_rows[i].dep);

    // fill the function table, then overflow it
    while (used_cnt < FUNC_ENTRIES) send_event(OP_ALLOC, 10'($urandom), clock_now);
    repeat (4) send_event(OP_ALLOC, 10'($urandom), clock_now, 1'b1, ST_TABLE, 13'(stack_lvl));

    rates = '{63'd1, MASK63, 63'd0, 63'd10000000, 63'd0, 63'd1000};
    rates[4] = 63'({$urandom, $urandom});
    foreach (rates[p]) begin
      set_rate(rates[p]);
      // large jumps with a tiny rate push the converted time into saturation
      if (p == 0) begin
        send_event(OP_ENTER, 10'd1023, 63'd0);
        send_event(OP_EXIT, 10'd1023, MASK63);
      end
      repeat (140) random_event();
    end

    // last part without idling
    quiet = 1;
    set_rate(63'd3000000);
    repeat (40) random_event();
    in_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d results checked over 7 frequency settings, function table driven full",
             checked);
    if (errors == 0 && expected_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
